FILE: hw/rtl/rie_pkg.sv
package rie_pkg;

  // field widths fixed by the request and response formats
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 6;
  localparam int SLOT_W   = 6;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;
  localparam int PIVOT_SLOTS = 64;

  // parameter defaults
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_WORD_WIDTH = 64;

  // commands
  localparam logic [CMD_W-1:0] CMD_WR_ELEM  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_PIVOT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_ELEM  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PIVOT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INDEX_RANGE = 2'd2;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PIVOT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_PIVOT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER = 3'd4;

  localparam logic [CNT_W-1:0]  RST_NUM_ROWS    = 7'd64;
  localparam logic [CNT_W-1:0]  RST_NUM_COLS    = 7'd64;
  localparam logic [SLOT_W-1:0] RST_FIRST_PIVOT = 6'd0;
  localparam logic [SLOT_W-1:0] RST_LAST_PIVOT  = 6'd63;
  localparam logic              RST_REVERSE     = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic [VALUE_W-1:0] element_value;
    logic [SLOT_W-1:0]  pivot_slot;
    logic [SLOT_W-1:0]  pivot_offset;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic wr_elem;
    logic rd_elem;
    logic wr_pivot;
    logic run_start;
    logic pv_read;
    logic pv_skip;
    logic col_start;
    logic col_read;
    logic wr_a;
    logic wr_b;
    logic col_next;
    logic slot_next;
    logic res_load_imm;
    logic res_load_rd;
    logic res_load_run;
    logic out_load_imm;
    logic out_load_res;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             in_range;
    logic             run_empty;
    logic             pv_ok;
    logic             cols_zero;
    logic             last_col;
    logic             last_slot;
  } dp_stat_t;

endpackage

FILE: hw/rtl/rie_ram.sv
module rie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/rie_datapath.sv
module rie_datapath #(
  parameter int MAX_ROWS   = rie_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = rie_pkg::DEF_MAX_COLS,
  parameter int WORD_WIDTH = rie_pkg::DEF_WORD_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rie_pkg::in_req_t                in_req_i,
  input  logic                            cfg_we_i,
  input  logic [rie_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rie_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  rie_pkg::ctrl_cmd_t              cmd_i,
  output rie_pkg::dp_stat_t               stat_o,
  output rie_pkg::out_rsp_t               out_rsp_o
);

  localparam int CNT_W       = rie_pkg::CNT_W;
  localparam int SLOT_W      = rie_pkg::SLOT_W;
  localparam int MAT_DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int MAT_AW      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int PV_AW       = $clog2(rie_pkg::PIVOT_SLOTS);
  localparam int ADDR_CALC_W = MAT_AW + CNT_W + 1;
  localparam int CNT_MAX     = (1 << CNT_W) - 1;
  localparam int ROW_CAP     = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;
  localparam int COL_CAP     = (MAX_COLS < CNT_MAX) ? MAX_COLS : CNT_MAX;

  function automatic logic [MAT_AW-1:0] mat_addr(input logic [CNT_W-1:0] row,
                                                 input logic [CNT_W-1:0] col);
    logic [ADDR_CALC_W-1:0] full;
    full = ADDR_CALC_W'(row) * ADDR_CALC_W'(MAX_COLS) + ADDR_CALC_W'(col);
    return full[MAT_AW-1:0];
  endfunction

  logic [CNT_W-1:0]  num_rows_q, num_cols_q;
  logic [SLOT_W-1:0] first_q, last_q;
  logic              reverse_q;
  logic [CNT_W-1:0]  rows_use, cols_use;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  target_q, target_d;
  logic [CNT_W-1:0]  col_q, col_d;
  logic              flag_q, flag_d;
  logic [CNT_W-1:0]  target;

  rie_pkg::out_rsp_t res_q, res_d;
  rie_pkg::out_rsp_t out_q, out_d;
  rie_pkg::out_rsp_t imm_rsp;

  logic [MAT_AW-1:0]     in_addr, addr_a, addr_b;
  logic                  mat_we, mat_re_a;
  logic [MAT_AW-1:0]     mat_waddr, mat_raddr_a;
  logic [WORD_WIDTH-1:0] mat_wdata, mat_rdata_a, mat_rdata_b;
  logic [SLOT_W-1:0]     pv_rdata;
  logic                  in_range;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= rie_pkg::RST_NUM_ROWS;
      num_cols_q <= rie_pkg::RST_NUM_COLS;
      first_q    <= rie_pkg::RST_FIRST_PIVOT;
      last_q     <= rie_pkg::RST_LAST_PIVOT;
      reverse_q  <= rie_pkg::RST_REVERSE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rie_pkg::CFG_NUM_ROWS:      num_rows_q <= cfg_data_i;
        rie_pkg::CFG_NUM_COLS:      num_cols_q <= cfg_data_i;
        rie_pkg::CFG_FIRST_PIVOT:   first_q    <= cfg_data_i[SLOT_W-1:0];
        rie_pkg::CFG_LAST_PIVOT:    last_q     <= cfg_data_i[SLOT_W-1:0];
        rie_pkg::CFG_REVERSE_ORDER: reverse_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rows_use = (int'(num_rows_q) < ROW_CAP) ? num_rows_q : CNT_W'(ROW_CAP);
  assign cols_use = (int'(num_cols_q) < COL_CAP) ? num_cols_q : CNT_W'(COL_CAP);

  assign in_range = ({1'b0, in_req_i.row_index} < rows_use) &&
                    ({1'b0, in_req_i.col_index} < cols_use);
  assign in_addr  = mat_addr({1'b0, in_req_i.row_index}, {1'b0, in_req_i.col_index});
  assign addr_a   = mat_addr({1'b0, slot_q}, col_q);
  assign addr_b   = mat_addr(target_q, col_q);
  assign target   = {1'b0, slot_q} + {1'b0, pv_rdata};

  always_comb begin
    imm_rsp.read_value = '0;
    imm_rsp.status     = rie_pkg::STATUS_OK;
    if ((in_req_i.command == rie_pkg::CMD_WR_ELEM ||
         in_req_i.command == rie_pkg::CMD_RD_ELEM) && !in_range) begin
      imm_rsp.status = rie_pkg::STATUS_INDEX_RANGE;
    end
  end

  // walk counters and result registers
  always_comb begin
    slot_d   = slot_q;
    target_d = target_q;
    col_d    = col_q;
    flag_d   = flag_q;
    res_d    = res_q;
    out_d    = out_q;
    if (cmd_i.run_start) begin
      slot_d = reverse_q ? last_q : first_q;
      flag_d = 1'b0;
    end
    if (cmd_i.slot_next) begin
      slot_d = reverse_q ? slot_q - 1'b1 : slot_q + 1'b1;
    end
    if (cmd_i.pv_skip) begin
      flag_d = 1'b1;
    end
    if (cmd_i.col_start) begin
      target_d = target;
      col_d    = '0;
    end
    if (cmd_i.col_next) begin
      col_d = col_q + 1'b1;
    end
    if (cmd_i.res_load_imm) begin
      res_d = imm_rsp;
    end
    if (cmd_i.res_load_rd) begin
      res_d.read_value = rie_pkg::VALUE_W'(mat_rdata_a);
      res_d.status     = rie_pkg::STATUS_OK;
    end
    if (cmd_i.res_load_run) begin
      res_d.read_value = '0;
      res_d.status     = flag_d ? rie_pkg::STATUS_PIVOT_RANGE : rie_pkg::STATUS_OK;
    end
    if (cmd_i.out_load_imm) begin
      out_d = imm_rsp;
    end
    if (cmd_i.out_load_res) begin
      out_d = res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    target_q <= target_d;
    col_q    <= col_d;
    flag_q   <= flag_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // matrix store port muxing
  assign mat_we      = cmd_i.wr_elem | cmd_i.wr_a | cmd_i.wr_b;
  assign mat_waddr   = cmd_i.wr_a ? addr_a : (cmd_i.wr_b ? addr_b : in_addr);
  assign mat_wdata   = cmd_i.wr_a ? mat_rdata_b :
                       (cmd_i.wr_b ? mat_rdata_a : in_req_i.element_value[WORD_WIDTH-1:0]);
  assign mat_re_a    = cmd_i.rd_elem | cmd_i.col_read;
  assign mat_raddr_a = cmd_i.col_read ? addr_a : in_addr;

  rie_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (MAT_DEPTH),
    .AW    (MAT_AW)
  ) u_matrix_ram (
    .clk_i     (clk_i),
    .we_i      (mat_we),
    .waddr_i   (mat_waddr),
    .wdata_i   (mat_wdata),
    .re_a_i    (mat_re_a),
    .raddr_a_i (mat_raddr_a),
    .rdata_a_o (mat_rdata_a),
    .re_b_i    (cmd_i.col_read),
    .raddr_b_i (addr_b),
    .rdata_b_o (mat_rdata_b)
  );

  rie_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (rie_pkg::PIVOT_SLOTS),
    .AW    (PV_AW)
  ) u_pivot_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr_pivot),
    .waddr_i   (in_req_i.pivot_slot),
    .wdata_i   (in_req_i.pivot_offset),
    .re_a_i    (cmd_i.pv_read),
    .raddr_a_i (slot_q),
    .rdata_a_o (pv_rdata),
    .re_b_i    (1'b0),
    .raddr_b_i ('0),
    .rdata_b_o ()
  );

  assign stat_o.command   = in_req_i.command;
  assign stat_o.in_range  = in_range;
  assign stat_o.run_empty = first_q > last_q;
  assign stat_o.pv_ok     = ({1'b0, slot_q} < rows_use) && (target < rows_use);
  assign stat_o.cols_zero = cols_use == '0;
  assign stat_o.last_col  = col_q == cols_use - 1'b1;
  assign stat_o.last_slot = reverse_q ? (slot_q == first_q) : (slot_q == last_q);

  assign out_rsp_o = out_q;

`ifndef SYNTHESIS
  a_swap_target_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_b |-> (target_q < rows_use && {1'b0, slot_q} < rows_use))
    else $error("swap write to a row outside the rows in use");
`endif

endmodule

FILE: hw/rtl/rie_controller.sv
module rie_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rie_pkg::dp_stat_t  stat_i,
  output rie_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_WAIT  = 3'd1;
  localparam logic [2:0] S_EMIT     = 3'd2;
  localparam logic [2:0] S_PV_FETCH = 3'd3;
  localparam logic [2:0] S_PV_CHECK = 3'd4;
  localparam logic [2:0] S_COL_RD   = 3'd5;
  localparam logic [2:0] S_COL_WA   = 3'd6;
  localparam logic [2:0] S_COL_WB   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.wr_elem  = (stat_i.command == rie_pkg::CMD_WR_ELEM) && stat_i.in_range;
          cmd_o.wr_pivot = stat_i.command == rie_pkg::CMD_WR_PIVOT;
          if (stat_i.command == rie_pkg::CMD_RD_ELEM && stat_i.in_range) begin
            cmd_o.rd_elem = 1'b1;
            state_d       = S_RD_WAIT;
          end else if (stat_i.command == rie_pkg::CMD_RUN && !stat_i.run_empty) begin
            cmd_o.run_start = 1'b1;
            state_d         = S_PV_FETCH;
          end else if (out_free) begin
            cmd_o.out_load_imm = 1'b1;
          end else begin
            cmd_o.res_load_imm = 1'b1;
            state_d            = S_EMIT;
          end
        end
      end
      S_RD_WAIT: begin
        cmd_o.res_load_rd = 1'b1;
        state_d           = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load_res = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_PV_FETCH: begin
        cmd_o.pv_read = 1'b1;
        state_d       = S_PV_CHECK;
      end
      S_PV_CHECK: begin
        if (stat_i.pv_ok && !stat_i.cols_zero) begin
          cmd_o.col_start = 1'b1;
          state_d         = S_COL_RD;
        end else begin
          cmd_o.pv_skip = !stat_i.pv_ok;
          if (stat_i.last_slot) begin
            cmd_o.res_load_run = 1'b1;
            state_d            = S_EMIT;
          end else begin
            cmd_o.slot_next = 1'b1;
            state_d         = S_PV_FETCH;
          end
        end
      end
      S_COL_RD: begin
        cmd_o.col_read = 1'b1;
        state_d        = S_COL_WA;
      end
      S_COL_WA: begin
        cmd_o.wr_a = 1'b1;
        state_d    = S_COL_WB;
      end
      S_COL_WB: begin
        cmd_o.wr_b = 1'b1;
        if (!stat_i.last_col) begin
          cmd_o.col_next = 1'b1;
          state_d        = S_COL_RD;
        end else if (stat_i.last_slot) begin
          cmd_o.res_load_run = 1'b1;
          state_d            = S_EMIT;
        end else begin
          cmd_o.slot_next = 1'b1;
          state_d         = S_PV_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (cmd_o.out_load_imm || cmd_o.out_load_res) ? 1'b1 :
                       (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_wa_then_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COL_WA |=> state_q == S_COL_WB)
    else $error("second half of a column swap was not written");
  a_run_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stat_i.command == rie_pkg::CMD_RUN && !stat_i.run_empty)
    |=> state_q == S_PV_FETCH)
    else $error("run request did not start the pivot walk");
  a_emit_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("pending response was not moved to the output register");
`endif

endmodule

FILE: hw/rtl/row_interchange_engine.sv
// row interchange engine: applies a sequence of row swaps to a stored matrix
// - input channel (in_valid_i / in_stall_o / in_req_i) takes one request per
//   accept; request codes: write element, write pivot offset, run swaps, read element
// - output channel (out_valid_o / out_stall_i / out_rsp_o) gives exactly one
//   response per request, in request order
// - config port: cfg_we_i writes cfg_data_i into register cfg_index_i, no wait;
//   the user writes it only while the block is idle, unenforced by the block
// - element and pivot writes, and requests with an index out of range: back to back
//   while the output register is free, each response registered there next cycle
// - element read: the registered matrix ram read, then the pending response register,
//   then the output register; no new request is taken meanwhile
// - run: per pivot slot a fetch and a check; per column of an applied slot two
//   reads, then two writes through the single write port
// - in_stall_o is high whenever the sequencer is busy; a request may be taken
//   while the previous response still waits in the output register
// - when the receiver stalls, the response holds in the output register and
//   the next response waits in a pending register
// - reset clears the sequencer and output valid, resets the config registers; matrix
//   and pivot stores are not cleared; user must read only after written, unenforced
module row_interchange_engine #(
  parameter int MAX_ROWS   = rie_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = rie_pkg::DEF_MAX_COLS,
  parameter int WORD_WIDTH = rie_pkg::DEF_WORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rie_pkg::in_req_t               in_req_i,
  // response channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rie_pkg::out_rsp_t              out_rsp_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [rie_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rie_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  rie_pkg::ctrl_cmd_t cmd;
  rie_pkg::dp_stat_t  stat;

  // sequencer: request decode, pivot walk, column swap steps, response handoff
  rie_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config registers, matrix and pivot rams, walk counters, results
  rie_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
